// ===== hw/rtl/rlpe_pkg.sv =====
// Shared types, constants and the color wheel function of the rainbow LED encoder.
package rlpe_pkg;

  // Default chain length.
  localparam int PIXEL_COUNT_DEF = 64;

  // Field widths.
  localparam int IDX_W   = 10;
  localparam int TS_W    = 32;
  localparam int DUTY_W  = 16;
  localparam int WAIT_W  = 8;
  localparam int HUE_W   = 8;
  localparam int GRB_W   = 24;
  localparam int CFG_IDX_W = 2;

  // Serializer constants: one beat per color bit.
  localparam int BITS_PER_PIXEL = GRB_W;
  localparam int BIT_CNT_W      = $clog2(BITS_PER_PIXEL);

  // Job queue between the front and back parts.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Color wheel segment bounds.
  localparam logic [7:0] WHEEL_SEG1 = 8'd85;
  localparam logic [7:0] WHEEL_SEG2 = 8'd170;
  localparam logic [7:0] WHEEL_MAX  = 8'd255;

  // Input commands.
  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_WHEEL = 2'd1,
    CMD_COLOR = 2'd2
  } cmd_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WAIT_MS     = 2'd0,
    REG_DUTY_ONE    = 2'd1,
    REG_DUTY_ZERO   = 2'd2,
    REG_SPREAD_MODE = 2'd3
  } reg_idx_t;

  // Configuration register set.
  typedef struct packed {
    logic [WAIT_W-1:0] wait_ms;
    logic [DUTY_W-1:0] duty_one;
    logic [DUTY_W-1:0] duty_zero;
    logic              spread_mode;
  } cfg_t;

  // One classified job: a tick result, a wheel hue or an explicit color.
  typedef struct packed {
    logic             tick;
    logic             adv;
    logic             wheel;
    logic [GRB_W-1:0] data;
  } job_t;

  // Three-segment color wheel, returns GRB with green in the high byte.
  function automatic logic [GRB_W-1:0] wheel_grb(input logic [HUE_W-1:0] hue);
    logic [7:0] p;
    logic [7:0] q;
    logic [9:0] q3;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    p = WHEEL_MAX - hue;
    if (p < WHEEL_SEG1) begin
      q = p;
    end else if (p < WHEEL_SEG2) begin
      q = p - WHEEL_SEG1;
    end else begin
      q = p - WHEEL_SEG2;
    end
    q3 = {2'b00, q} + {1'b0, q, 1'b0};
    if (p < WHEEL_SEG1) begin
      r = WHEEL_MAX - q3[7:0];
      g = 8'd0;
      b = q3[7:0];
    end else if (p < WHEEL_SEG2) begin
      r = 8'd0;
      g = q3[7:0];
      b = WHEEL_MAX - q3[7:0];
    end else begin
      r = q3[7:0];
      g = WHEEL_MAX - q3[7:0];
      b = 8'd0;
    end
    return {g, r, b};
  endfunction

endpackage

// ===== hw/rtl/rlpe_front.sv =====
// Front part: accepts items, keeps the frame timer and hue phase, classifies jobs.
module rlpe_front import rlpe_pkg::*; #(
  parameter int PIXEL_COUNT = PIXEL_COUNT_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  input  logic             in_fire,
  input  logic [1:0]       cmd,
  input  logic [TS_W-1:0]  timestamp,
  input  logic [IDX_W-1:0] pixel_index,
  input  logic [GRB_W-1:0] color,
  output logic             job_push,
  output job_t             job
);

  localparam logic [IDX_W:0] PCOUNT = (IDX_W+1)'(PIXEL_COUNT);

  // Scaled reciprocal of the chain length: ceil(2^RECIP_SHIFT / PIXEL_COUNT).
  localparam int RECIP_SHIFT = 28;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int PROD_W      = IDX_W + RECIP_W;
  localparam logic [RECIP_W-1:0] SPREAD_RECIP =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(PIXEL_COUNT) - 64'd1) / 64'(PIXEL_COUNT));

  logic [HUE_W-1:0] hue_phase;
  logic [TS_W-1:0]  next_due;
  logic             started;

  logic [TS_W-1:0]   due_base;
  logic              due;
  logic              in_range;
  logic [PROD_W-1:0] spread_prod;
  logic [HUE_W-1:0]  spread_pos;
  logic [HUE_W-1:0]  hue;

  // Frame due test; in spread mode the first tick latches its timestamp.
  always_comb begin
    due_base = (cfg.spread_mode && !started) ? timestamp : next_due;
    if (cfg.spread_mode) begin
      due = timestamp > due_base;
    end else begin
      due = (next_due < {{(TS_W-WAIT_W){1'b0}}, cfg.wait_ms}) || (timestamp > next_due);
    end
  end

  // Spread position index*256/PIXEL_COUNT as a multiply by the scaled reciprocal.
  // The reciprocal is exact for every index below the chain length.
  assign spread_prod = {{RECIP_W{1'b0}}, pixel_index} * {{IDX_W{1'b0}}, SPREAD_RECIP};
  assign spread_pos  = spread_prod[RECIP_SHIFT-1:RECIP_SHIFT-HUE_W];

  assign in_range = {1'b0, pixel_index} < PCOUNT;
  assign hue = cfg.spread_mode ? (spread_pos + hue_phase)
                               : (pixel_index[HUE_W-1:0] + hue_phase);

  // Classification into a queue job; out-of-range and unused commands are dropped.
  always_comb begin
    job_push = 1'b0;
    job      = '0;
    case (cmd_t'(cmd))
      CMD_TICK: begin
        job_push = in_fire;
        job.tick = 1'b1;
        job.adv  = due;
      end
      CMD_WHEEL: begin
        job_push   = in_fire && in_range;
        job.wheel  = 1'b1;
        job.data   = {{(GRB_W-HUE_W){1'b0}}, hue};
      end
      CMD_COLOR: begin
        job_push = in_fire && in_range;
        job.data = color;
      end
      default: begin
        job_push = 1'b0;
      end
    endcase
  end

  // Frame timer state, updated by each accepted tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      hue_phase <= '0;
      next_due  <= '0;
      started   <= 1'b0;
    end else if (in_fire && (cmd_t'(cmd) == CMD_TICK)) begin
      if (cfg.spread_mode && !started) begin
        started  <= 1'b1;
        next_due <= timestamp;
      end
      if (due) begin
        hue_phase <= hue_phase + 1'b1;
        next_due  <= timestamp + {{(TS_W-WAIT_W){1'b0}}, cfg.wait_ms};
      end
    end
  end

endmodule

// ===== hw/rtl/rlpe_queue.sv =====
// Short job queue between the front and back parts.
module rlpe_queue import rlpe_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t wdata,
  input  logic pop,
  output job_t rdata,
  output logic full,
  output logic not_empty
);

  job_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full      = count == (QPTR_W+1)'(QUEUE_DEPTH);
  assign not_empty = count != '0;
  assign rdata     = slots[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Job storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

endmodule

// ===== hw/rtl/rlpe_back.sv =====
// Back part: color wheel lookup and 24-beat bit serializer into the result register.
module rlpe_back import rlpe_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              q_valid,
  input  job_t              q_job,
  output logic              q_pop,
  output logic              empty,
  input  logic              pop,
  output logic [DUTY_W-1:0] duty,
  output logic              last,
  output logic              frame_advanced
);

  localparam logic [BIT_CNT_W-1:0] LAST_BIT = BIT_CNT_W'(BITS_PER_PIXEL - 1);

  logic                 out_valid;
  logic                 busy;
  logic [GRB_W-1:0]     sh;
  logic [BIT_CNT_W-1:0] cnt;

  logic             load;
  logic             beat;
  logic             beat_bit;
  logic             beat_last;
  logic             beat_adv;
  logic             beat_tick;
  logic [GRB_W-1:0] grb;

  assign empty = !out_valid;
  assign load  = !out_valid || pop;

  // Next beat: from the running pixel, or straight from the queue head.
  always_comb begin
    q_pop     = 1'b0;
    beat      = 1'b0;
    beat_bit  = 1'b0;
    beat_last = 1'b0;
    beat_adv  = 1'b0;
    beat_tick = 1'b0;
    grb       = q_job.wheel ? wheel_grb(q_job.data[HUE_W-1:0]) : q_job.data;
    if (busy) begin
      beat      = load;
      beat_bit  = sh[GRB_W-1];
      beat_last = cnt == LAST_BIT;
    end else if (q_valid) begin
      beat  = load;
      q_pop = load;
      if (q_job.tick) begin
        beat_tick = 1'b1;
        beat_last = 1'b1;
        beat_adv  = q_job.adv;
      end else begin
        beat_bit = grb[GRB_W-1];
      end
    end
  end

  // Serializer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      if (load) begin
        sh  <= {sh[GRB_W-2:0], 1'b0};
        cnt <= cnt + 1'b1;
        if (cnt == LAST_BIT) begin
          busy <= 1'b0;
        end
      end
    end else if (q_pop && !q_job.tick) begin
      sh   <= {grb[GRB_W-2:0], 1'b0};
      cnt  <= BIT_CNT_W'(1);
      busy <= 1'b1;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (beat) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (beat) begin
      duty           <= beat_tick ? '0 : (beat_bit ? cfg.duty_one : cfg.duty_zero);
      last           <= beat_last;
      frame_advanced <= beat_adv;
    end
  end

endmodule

// ===== hw/rtl/rainbow_led_pattern_encoder_unit.sv =====
// Top level of the rainbow LED pattern encoder.
//
// Input channel: push/full. An item is a tick (cmd 0) with a millisecond
// timestamp, a rainbow pixel request (cmd 1) or an explicit color request
// (cmd 2). Result channel: empty/pop; duty, last and frame_advanced show the
// oldest result while empty is low. Configuration: cfg_valid/cfg_ready with
// cfg_index and cfg_data; cfg_ready is always high, write only while idle.
// The result of a beat is registered and shows in the cycle after the beat.
// Throughput: a pixel request gives 24 beats, one per cycle while the result
// register is empty or popped; a tick gives one beat. The bit serializer of
// the back part sets this rate. A four-entry job queue lets the front keep
// accepting while the serializer works; full rises once it fills.
// Requests with an index beyond the chain and command 3 give no result.
// Reset clears the hue phase, frame timer, queue and result register and
// loads the register defaults. If the receiver stalls, the result holds and
// the queue fills, then full stops the sender.
module rainbow_led_pattern_encoder_unit import rlpe_pkg::*; #(
  parameter int PIXEL_COUNT = PIXEL_COUNT_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic [1:0]           cmd,
  input  logic [TS_W-1:0]      timestamp,
  input  logic [IDX_W-1:0]     pixel_index,
  input  logic [GRB_W-1:0]     color,
  output logic                 empty,
  input  logic                 pop,
  output logic [DUTY_W-1:0]    duty,
  output logic                 last,
  output logic                 frame_advanced,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DUTY_W-1:0]    cfg_data
);

  cfg_t cfg;
  logic in_fire;
  logic job_push;
  job_t job;
  job_t q_job;
  logic q_valid;
  logic q_pop;

  assign cfg_ready = 1'b1;
  assign in_fire   = push && !full;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.wait_ms     <= WAIT_W'(20);
      cfg.duty_one    <= '0;
      cfg.duty_zero   <= '0;
      cfg.spread_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_WAIT_MS:     cfg.wait_ms     <= cfg_data[WAIT_W-1:0];
        REG_DUTY_ONE:    cfg.duty_one    <= cfg_data;
        REG_DUTY_ZERO:   cfg.duty_zero   <= cfg_data;
        REG_SPREAD_MODE: cfg.spread_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  rlpe_front #(
    .PIXEL_COUNT(PIXEL_COUNT)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_fire     (in_fire),
    .cmd         (cmd),
    .timestamp   (timestamp),
    .pixel_index (pixel_index),
    .color       (color),
    .job_push    (job_push),
    .job         (job)
  );

  rlpe_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (job_push),
    .wdata     (job),
    .pop       (q_pop),
    .rdata     (q_job),
    .full      (full),
    .not_empty (q_valid)
  );

  rlpe_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .q_valid        (q_valid),
    .q_job          (q_job),
    .q_pop          (q_pop),
    .empty          (empty),
    .pop            (pop),
    .duty           (duty),
    .last           (last),
    .frame_advanced (frame_advanced)
  );

endmodule

// ===== hw/rtl/rlpe_checker.sv =====
// Port-level checker for the rainbow LED encoder and its bind to the top level.
module rlpe_checker import rlpe_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              full,
  input logic              empty,
  input logic              pop,
  input logic [DUTY_W-1:0] duty,
  input logic              last,
  input logic              frame_advanced
);

  // Reset leaves no result waiting.
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result channel not empty after reset");

  // Reset leaves room in the queue.
  a_reset_not_full: assert property (@(posedge clk) rst |=> !full)
    else $error("queue full after reset");

  // A stalled result beat holds its payload.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(duty) && $stable(last) && $stable(frame_advanced)))
    else $error("stalled result changed");

  // A frame advance only shows on a tick result, which is a single zero beat.
  a_adv_is_tick: assert property (@(posedge clk) disable iff (rst)
    (!empty && frame_advanced) |-> (last && (duty == '0)))
    else $error("frame advance on a pixel beat");

endmodule

bind rainbow_led_pattern_encoder_unit rlpe_checker u_rlpe_checker (
  .clk            (clk),
  .rst            (rst),
  .full           (full),
  .empty          (empty),
  .pop            (pop),
  .duty           (duty),
  .last           (last),
  .frame_advanced (frame_advanced)
);

// ===== bench/tb_rainbow_led_pattern_encoder_unit.sv =====
// Self-checking testbench for the rainbow LED pattern encoder top level.
`timescale 1ns / 100ps

module tb_rainbow_led_pattern_encoder_unit;
  import rlpe_pkg::*;

  localparam int PIXEL_COUNT = PIXEL_COUNT_DEF;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  // Cycles to wait after the last expected beat, so that items with no beat finish too.
  localparam int DRAIN_TAIL = 8;

  typedef enum {STEP_ITEM, STEP_CFG, STEP_DRAIN, STEP_PHASE} step_kind_t;

  // One entry of the stimulus script.
  typedef struct {
    step_kind_t  kind;
    logic [1:0]  cmd;
    logic [31:0] ts;
    logic [9:0]  idx;
    logic [23:0] col;
    reg_idx_t    cfg_sel;
    logic [15:0] value;
    int          idle_send;
    int          idle_recv;
  } step_t;

  // One expected result beat.
  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic              last;
    logic              adv;
  } beat_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 push = 1'b0;
  logic                 full;
  logic [1:0]           cmd = 2'd0;
  logic [TS_W-1:0]      timestamp = '0;
  logic [IDX_W-1:0]     pixel_index = '0;
  logic [GRB_W-1:0]     color = '0;
  logic                 empty;
  logic                 pop = 1'b0;
  logic [DUTY_W-1:0]    duty;
  logic                 last;
  logic                 frame_advanced;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DUTY_W-1:0]    cfg_data = '0;

  rainbow_led_pattern_encoder_unit #(
    .PIXEL_COUNT(PIXEL_COUNT)
  ) u_top (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .cmd           (cmd),
    .timestamp     (timestamp),
    .pixel_index   (pixel_index),
    .color         (color),
    .empty         (empty),
    .pop           (pop),
    .duty          (duty),
    .last          (last),
    .frame_advanced(frame_advanced),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // Encoder state and register copy kept alongside the block.
  logic [7:0]  wait_q = 8'd20;
  logic [15:0] duty_one_q = 16'd0;
  logic [15:0] duty_zero_q = 16'd0;
  logic        spread_q = 1'b0;
  logic [7:0]  hue_phase_q = 8'd0;
  logic [31:0] next_due_q = 32'd0;
  logic        started_q = 1'b0;

  step_t steps[$];
  beat_t pending_beats[$];

  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          mismatches = 0;
  int          cycle_count = 0;
  bit          drain_active = 1'b0;
  int          drain_left = 0;
  bit          stim_done = 1'b0;
  logic [31:0] ts_clock = 32'd0;

  // Three-segment color wheel, GRB with green in the high byte.
  function automatic logic [23:0] hue_to_grb(input logic [7:0] hue);
    int unsigned p;
    int unsigned r;
    int unsigned g;
    int unsigned b;
    p = 255 - hue;
    if (p < 85) begin
      r = 255 - 3 * p;
      g = 0;
      b = 3 * p;
    end else if (p < 170) begin
      p = p - 85;
      r = 0;
      g = 3 * p;
      b = 255 - 3 * p;
    end else begin
      p = p - 170;
      r = 3 * p;
      g = 255 - 3 * p;
      b = 0;
    end
    return {g[7:0], r[7:0], b[7:0]};
  endfunction

  // Mirror a register write into the local register copy.
  task automatic apply_cfg(input logic [CFG_IDX_W-1:0] sel, input logic [15:0] v);
    case (sel)
      REG_WAIT_MS:     wait_q = v[7:0];
      REG_DUTY_ONE:    duty_one_q = v;
      REG_DUTY_ZERO:   duty_zero_q = v;
      REG_SPREAD_MODE: spread_q = v[0];
      default: ;
    endcase
  endtask

  // Work out the beats that one accepted item causes and queue them.
  task automatic encode_item(input logic [1:0] c, input logic [31:0] ts,
                             input logic [9:0] idx, input logic [23:0] col);
    logic        due;
    logic [7:0]  hue;
    logic [23:0] grb;
    int unsigned spread_hue;
    beat_t       b;
    if (c == CMD_TICK) begin
      if (!spread_q) begin
        due = (next_due_q < {24'd0, wait_q}) || (ts > next_due_q);
      end else begin
        if (!started_q) begin
          next_due_q = ts;
          started_q = 1'b1;
        end
        due = ts > next_due_q;
      end
      if (due) begin
        hue_phase_q = hue_phase_q + 8'd1;
        next_due_q = ts + {24'd0, wait_q};
      end
      b.duty = '0;
      b.last = 1'b1;
      b.adv = due;
      pending_beats.push_back(b);
    end else if (c != CMD_UNUSED && idx < PIXEL_COUNT) begin
      if (c == CMD_COLOR) begin
        grb = col;
      end else begin
        if (!spread_q) begin
          hue = idx[7:0] + hue_phase_q;
        end else begin
          spread_hue = (int'(idx) * 256) / PIXEL_COUNT;
          hue = spread_hue[7:0] + hue_phase_q;
        end
        grb = hue_to_grb(hue);
      end
      // Green, red, blue, most significant bit first.
      for (int k = 0; k < 24; k++) begin
        b.duty = grb[23-k] ? duty_one_q : duty_zero_q;
        b.last = (k == 23);
        b.adv = 1'b0;
        pending_beats.push_back(b);
      end
    end
  endtask

  // Script helpers.
  task automatic add_item(input logic [1:0] c, input logic [31:0] ts,
                          input logic [9:0] idx, input logic [23:0] col);
    step_t s;
    s.kind = STEP_ITEM;
    s.cmd = c;
    s.ts = ts;
    s.idx = idx;
    s.col = col;
    steps.push_back(s);
  endtask

  task automatic add_cfg(input reg_idx_t sel, input logic [15:0] v);
    step_t s;
    s.kind = STEP_CFG;
    s.cfg_sel = sel;
    s.value = v;
    steps.push_back(s);
  endtask

  task automatic add_drain();
    step_t s;
    s.kind = STEP_DRAIN;
    steps.push_back(s);
  endtask

  task automatic add_phase(input int s_pct, input int r_pct);
    step_t s;
    s.kind = STEP_PHASE;
    s.idle_send = s_pct;
    s.idle_recv = r_pct;
    steps.push_back(s);
  endtask

  // Write every register with a fresh setting, extremes favored for the wait.
  task automatic add_random_cfg();
    int          roll;
    logic [15:0] wait_val;
    roll = $urandom_range(99);
    if (roll < 20) begin
      wait_val = 16'd0;
    end else if (roll < 40) begin
      wait_val = 16'd255;
    end else begin
      wait_val = 16'($urandom_range(255));
    end
    add_cfg(REG_WAIT_MS, wait_val);
    add_cfg(REG_DUTY_ONE, 16'($urandom_range(65535)));
    add_cfg(REG_DUTY_ZERO, 16'($urandom_range(65535)));
    add_cfg(REG_SPREAD_MODE, 16'($urandom_range(1)));
  endtask

  // Random items: mostly ticks on a running clock and in-range pixels.
  task automatic add_random_items(input int count);
    int roll;
    int done;
    done = 0;
    while (done < count) begin
      roll = $urandom_range(99);
      if (roll < 30) begin
        case ($urandom_range(9))
          0:       ts_clock = $urandom;
          1:       ts_clock = 32'hFFFF_FFFF - $urandom_range(30);
          2, 3:    ;
          default: ts_clock = ts_clock + $urandom_range(40);
        endcase
        add_item(CMD_TICK, ts_clock, 10'($urandom_range(1023)), 24'($urandom));
        done++;
      end else if (roll < 62) begin
        add_item(CMD_WHEEL, $urandom, 10'($urandom_range(PIXEL_COUNT - 1)), 24'($urandom));
        done++;
      end else if (roll < 90) begin
        add_item(CMD_COLOR, $urandom, 10'($urandom_range(PIXEL_COUNT - 1)), 24'($urandom));
        done++;
      end else if (roll < 95) begin
        add_item($urandom_range(1) ? CMD_WHEEL : CMD_COLOR, $urandom,
                 10'($urandom_range(1023, PIXEL_COUNT)), 24'($urandom));
      end else begin
        add_item(CMD_UNUSED, $urandom, 10'($urandom_range(1023)), 24'($urandom));
      end
      // Now and then hold the sender until all results are out.
      if ($urandom_range(99) < 2) begin
        add_drain();
      end
    end
  endtask

  // Clock.
  initial begin
    forever #6 clk = ~clk;
  end

  // Reset, script and end of run.
  initial begin
    // Directed part, mode 0 with full-scale one and zero duty words.
    add_phase(6, 57);
    add_cfg(REG_WAIT_MS, 16'd20);
    add_cfg(REG_DUTY_ONE, 16'hFFFF);
    add_cfg(REG_DUTY_ZERO, 16'h0000);
    add_cfg(REG_SPREAD_MODE, 16'd0);
    add_item(CMD_TICK, 32'd0, 10'd0, 24'd0);
    add_item(CMD_TICK, 32'd20, 10'd0, 24'd0);
    add_item(CMD_TICK, 32'd21, 10'd0, 24'd0);
    add_item(CMD_WHEEL, 32'd0, 10'd0, 24'd0);
    add_item(CMD_WHEEL, 32'hFFFF_FFFF, 10'd63, 24'hFFFFFF);
    add_item(CMD_WHEEL, 32'd0, 10'd64, 24'd0);
    add_item(CMD_WHEEL, 32'd0, 10'd1023, 24'd0);
    add_item(CMD_COLOR, 32'd0, 10'd5, 24'hFFFFFF);
    add_item(CMD_COLOR, 32'd0, 10'd0, 24'h000000);
    add_item(CMD_COLOR, 32'd0, 10'd63, 24'hA5A55A);
    add_item(CMD_COLOR, 32'd0, 10'd64, 24'hFFFFFF);
    add_item(CMD_UNUSED, 32'd0, 10'd0, 24'hFFFFFF);
    // Due time wraps past the top of the counter.
    add_item(CMD_TICK, 32'hFFFF_FFFF, 10'd0, 24'd0);
    add_item(CMD_TICK, 32'd0, 10'd0, 24'd0);
    add_item(CMD_WHEEL, 32'd0, 10'd17, 24'd0);
    add_drain();
    // Mode 1 with inverted duty words and no wait.
    add_cfg(REG_SPREAD_MODE, 16'd1);
    add_cfg(REG_DUTY_ONE, 16'h0000);
    add_cfg(REG_DUTY_ZERO, 16'hFFFF);
    add_cfg(REG_WAIT_MS, 16'd0);
    add_item(CMD_TICK, 32'd1000, 10'd0, 24'd0);
    add_item(CMD_TICK, 32'd1000, 10'd0, 24'd0);
    add_item(CMD_TICK, 32'd1001, 10'd0, 24'd0);
    add_item(CMD_WHEEL, 32'd0, 10'd0, 24'd0);
    add_item(CMD_WHEEL, 32'd0, 10'd63, 24'd0);
    add_item(CMD_WHEEL, 32'd0, 10'd32, 24'd0);
    add_drain();
    add_cfg(REG_WAIT_MS, 16'd255);
    add_item(CMD_TICK, 32'd1002, 10'd0, 24'd0);
    add_item(CMD_TICK, 32'd1300, 10'd0, 24'd0);
    add_item(CMD_WHEEL, 32'd0, 10'd21, 24'd0);
    // Random part in three idling phases.
    for (int seg = 0; seg < 6; seg++) begin
      if (seg == 2) begin
        add_drain();
        add_phase(57, 6);
      end else if (seg == 4) begin
        add_drain();
        add_phase(0, 0);
      end
      add_drain();
      add_random_cfg();
      add_random_items(28);
    end
    add_drain();

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    wait (stim_done);
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (2 * DRAIN_TAIL) @(posedge clk);
    if (mismatches == 0 && pending_beats.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Driver: works through the script, one input or register beat at a time.
  always @(posedge clk) begin
    logic  push_n;
    logic  cfg_n;
    step_t s;
    if (rst) begin
      push <= 1'b0;
      cfg_valid <= 1'b0;
    end else begin
      push_n = push;
      cfg_n = cfg_valid;
      if (push && !full) begin
        encode_item(cmd, timestamp, pixel_index, color);
        push_n = 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        apply_cfg(cfg_index, cfg_data);
        cfg_n = 1'b0;
      end
      if (!push_n && !cfg_n) begin
        if (drain_active) begin
          // Hold until every beat is out, then count down drain_left.
          if (pending_beats.size() == 0) begin
            if (drain_left == 0) begin
              drain_active = 1'b0;
            end else begin
              drain_left--;
            end
          end
        end else if (steps.size() != 0) begin
          s = steps[0];
          case (s.kind)
            STEP_ITEM: begin
              if ($urandom_range(99) >= send_idle_pct) begin
                cmd <= s.cmd;
                timestamp <= s.ts;
                pixel_index <= s.idx;
                color <= s.col;
                push_n = 1'b1;
                steps.pop_front();
              end
            end
            STEP_CFG: begin
              cfg_index <= s.cfg_sel;
              cfg_data <= s.value;
              cfg_n = 1'b1;
              steps.pop_front();
            end
            STEP_PHASE: begin
              send_idle_pct = s.idle_send;
              recv_idle_pct = s.idle_recv;
              steps.pop_front();
            end
            default: begin
              drain_active = 1'b1;
              drain_left = DRAIN_TAIL;
              steps.pop_front();
            end
          endcase
        end else begin
          stim_done = 1'b1;
        end
      end
      push <= push_n;
      cfg_valid <= cfg_n;
    end
  end

  // Monitor: checks each popped beat against the oldest expectation.
  always @(posedge clk) begin
    beat_t exp_b;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (pending_beats.size() == 0) begin
          $error("unexpected beat: duty %h last %b frame_advanced %b",
                 duty, last, frame_advanced);
          mismatches++;
        end else begin
          exp_b = pending_beats.pop_front();
          if (duty !== exp_b.duty) begin
            $error("duty: expected %h, actual %h", exp_b.duty, duty);
            mismatches++;
          end
          if (last !== exp_b.last) begin
            $error("last: expected %b, actual %b", exp_b.last, last);
            mismatches++;
          end
          if (frame_advanced !== exp_b.adv) begin
            $error("frame_advanced: expected %b, actual %b", exp_b.adv, frame_advanced);
            mismatches++;
          end
        end
      end
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

endmodule
